/* design/hcbi_pkg.sv */
// Shared types and codes for the hand controller button interpreter.
`timescale 1ns / 1ps

package hcbi_pkg;

   localparam int LEVEL_W = 10;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 32;
   localparam int MODE_W  = 10;
   localparam int CSR_IDX_W = 3;

   // Highest step mode that may still be doubled
   localparam logic [MODE_W-1:0] MODE_DOUBLE_MAX = 10'd256;
   localparam logic [MODE_W-1:0] MODE_BASE = 10'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UP_LOW       = 3'd0,
      CSR_UP_HIGH      = 3'd1,
      CSR_DOWN_LOW     = 3'd2,
      CSR_DOWN_HIGH    = 3'd3,
      CSR_BOTH_LOW     = 3'd4,
      CSR_BOTH_HIGH    = 3'd5,
      CSR_PRESENT_LOW  = 3'd6,
      CSR_PRESENT_HIGH = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      BTN_NONE = 3'd0,
      BTN_UP   = 3'd1,
      BTN_DOWN = 3'd2,
      BTN_BOTH = 3'd3,
      BTN_OFF  = 3'd4
   } btn_type;

   typedef enum logic [2:0] {
      MOVE_NONE      = 3'd0,
      MOVE_NUDGE_UP  = 3'd1,
      MOVE_NUDGE_DN  = 3'd2,
      MOVE_CONT_UP   = 3'd3,
      MOVE_CONT_DN   = 3'd4
   } move_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] up_low;
      logic [LEVEL_W-1:0] up_high;
      logic [LEVEL_W-1:0] down_low;
      logic [LEVEL_W-1:0] down_high;
      logic [LEVEL_W-1:0] both_low;
      logic [LEVEL_W-1:0] both_high;
      logic [LEVEL_W-1:0] present_low;
      logic [LEVEL_W-1:0] present_high;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]       now_ms;
      logic [LEVEL_W-1:0]      level_a;
      logic [LEVEL_W-1:0]      level_b;
      logic [LEVEL_W-1:0]      level_c;
      logic [LEVEL_W-1:0]      level_d;
      logic                    motor_busy;
      logic                    manual_busy;
      logic                    manual_continuous;
      logic signed [POS_W-1:0] current_position;
      logic [MODE_W-1:0]       current_step_mode;
   } req_item_type;

   // Decoded view of the averaged level
   typedef struct packed {
      btn_type band;     // BTN_OFF means outside the presence window
      logic    present;  // strictly inside the presence window
   } level_info_type;

   typedef struct packed {
      btn_type                 button;
      logic                    linked;
      logic                    stop_cmd;
      move_type                move_cmd;
      logic                    target_valid;
      logic signed [POS_W-1:0] target_position;
      logic                    mode_valid;
      logic [MODE_W-1:0]       new_step_mode;
   } rsp_item_type;

endpackage

/* design/hcbi_if.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface hcbi_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [9:0]  level_a;
   logic [9:0]  level_b;
   logic [9:0]  level_c;
   logic [9:0]  level_d;
   logic        motor_busy;
   logic        manual_busy;
   logic        manual_continuous;
   logic signed [31:0] current_position;
   logic [9:0]  current_step_mode;

   modport source (
      output valid, now_ms, level_a, level_b, level_c, level_d, motor_busy,
             manual_busy, manual_continuous, current_position, current_step_mode,
      input  ready
   );
   modport sink (
      input  valid, now_ms, level_a, level_b, level_c, level_d, motor_busy,
             manual_busy, manual_continuous, current_position, current_step_mode,
      output ready
   );
endinterface

interface hcbi_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  button;
   logic        linked;
   logic        stop_cmd;
   logic [2:0]  move_cmd;
   logic        target_valid;
   logic signed [31:0] target_position;
   logic        mode_valid;
   logic [9:0]  new_step_mode;

   modport source (
      output valid, button, linked, stop_cmd, move_cmd, target_valid,
             target_position, mode_valid, new_step_mode,
      input  ready
   );
   modport sink (
      input  valid, button, linked, stop_cmd, move_cmd, target_valid,
             target_position, mode_valid, new_step_mode,
      output ready
   );
endinterface

/* design/hcbi_csr.sv */
// Threshold register file of the button interpreter.
`timescale 1ns / 1ps

module hcbi_csr
   import hcbi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [LEVEL_W-1:0]   wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   // Register writes, one field per index
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_low       <= '0;
         cfg_ff.up_high      <= '0;
         cfg_ff.down_low     <= '0;
         cfg_ff.down_high    <= '0;
         cfg_ff.both_low     <= '0;
         cfg_ff.both_high    <= '0;
         cfg_ff.present_low  <= '0;
         cfg_ff.present_high <= '1;
      end else if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_UP_LOW:       cfg_ff.up_low       <= wr_data;
            CSR_UP_HIGH:      cfg_ff.up_high      <= wr_data;
            CSR_DOWN_LOW:     cfg_ff.down_low     <= wr_data;
            CSR_DOWN_HIGH:    cfg_ff.down_high    <= wr_data;
            CSR_BOTH_LOW:     cfg_ff.both_low     <= wr_data;
            CSR_BOTH_HIGH:    cfg_ff.both_high    <= wr_data;
            CSR_PRESENT_LOW:  cfg_ff.present_low  <= wr_data;
            CSR_PRESENT_HIGH: cfg_ff.present_high <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/hcbi_level.sv */
// Sample averaging and button band decode.
`timescale 1ns / 1ps

module hcbi_level
   import hcbi_pkg::*;
(
   input  req_item_type   item,
   input  cfg_type        cfg,
   output level_info_type info
);

   logic [LEVEL_W-1:0]   samp_a, samp_b, samp_c, samp_d;
   logic [LEVEL_W+1:0]   sum;
   logic [LEVEL_W-1:0]   avg;

   // Low samples count as zero, the divide stays fixed at four
   assign samp_a = (item.level_a >= cfg.present_low) ? item.level_a : '0;
   assign samp_b = (item.level_b >= cfg.present_low) ? item.level_b : '0;
   assign samp_c = (item.level_c >= cfg.present_low) ? item.level_c : '0;
   assign samp_d = (item.level_d >= cfg.present_low) ? item.level_d : '0;
   assign sum = {2'b00, samp_a} + {2'b00, samp_b} + {2'b00, samp_c} + {2'b00, samp_d};
   assign avg = sum[LEVEL_W+1:2];

   // Priority decode: up, down, both, then the presence window
   always_comb begin
      info.present = (avg > cfg.present_low) && (avg < cfg.present_high);
      if (avg > cfg.up_low && avg < cfg.up_high)
         info.band = BTN_UP;
      else if (avg > cfg.down_low && avg < cfg.down_high)
         info.band = BTN_DOWN;
      else if (avg > cfg.both_low && avg < cfg.both_high)
         info.band = BTN_BOTH;
      else if (avg > cfg.present_high || avg < cfg.present_low)
         info.band = BTN_OFF;
      else
         info.band = BTN_NONE;
   end

endmodule

/* design/hcbi_core.sv */
// Connection, poll timing and press handling state with command decode.
`timescale 1ns / 1ps

module hcbi_core
   import hcbi_pkg::*;
#(
   parameter int HOLD_TIMEOUT_MS       = 500,
   parameter int MODE_RESET_TIMEOUT_MS = 2000,
   parameter int POLL_MS               = 20,
   parameter int DISCOVERY_MS          = 300,
   parameter int NUDGE_STEPS           = 100
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_item_type   item,
   input  level_info_type info,
   output rsp_item_type   result
);

   localparam logic [TIME_W-1:0] HoldT  = TIME_W'(HOLD_TIMEOUT_MS);
   localparam logic [TIME_W-1:0] ModeT  = TIME_W'(MODE_RESET_TIMEOUT_MS);
   localparam logic [TIME_W-1:0] PollT  = TIME_W'(POLL_MS);
   localparam logic [TIME_W-1:0] DiscT  = TIME_W'(DISCOVERY_MS);
   localparam logic [POS_W-1:0]  NudgeS = POS_W'(NUDGE_STEPS);

   logic              connected_ff, connected_in;
   logic [TIME_W-1:0] up_at_ff, up_at_in;
   logic [TIME_W-1:0] down_at_ff, down_at_in;
   logic [TIME_W-1:0] both_at_ff, both_at_in;
   logic [TIME_W-1:0] last_poll_ff, last_poll_in;
   logic [TIME_W-1:0] last_disc_ff, last_disc_in;
   logic              pending_ff, pending_in;

   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] disc_age, poll_age, up_age, down_age, both_age;
   logic              disc_due, conn_mid, poll, cont, released;
   logic              up_short, down_short;

   assign now      = item.now_ms;
   assign cont     = item.manual_continuous;
   assign disc_age = now - last_disc_ff;
   assign poll_age = now - last_poll_ff;
   assign up_age   = now - up_at_ff;
   assign down_age = now - down_at_ff;
   assign both_age = now - both_at_ff;

   assign disc_due   = (disc_age > DiscT) || (last_disc_ff == '0);
   assign conn_mid   = connected_ff || (disc_due && info.present);
   assign poll       = conn_mid && !(item.motor_busy && !cont) && (poll_age >= PollT);
   assign released   = (info.band == BTN_NONE) || (info.band == BTN_OFF);
   assign up_short   = (up_at_ff != '0) && (up_age <= HoldT);
   assign down_short = (down_at_ff != '0) && (down_age <= HoldT);

   // Next state and result of the tick in the input register
   always_comb begin
      connected_in = conn_mid;
      up_at_in     = up_at_ff;
      down_at_in   = down_at_ff;
      both_at_in   = both_at_ff;
      last_poll_in = last_poll_ff;
      last_disc_in = disc_due ? now : last_disc_ff;
      pending_in   = pending_ff;

      result.button          = BTN_OFF;
      result.stop_cmd        = 1'b0;
      result.move_cmd        = MOVE_NONE;
      result.target_valid    = 1'b0;
      result.target_position = '0;
      result.mode_valid      = 1'b0;
      result.new_step_mode   = '0;

      if (poll) begin
         last_poll_in  = now;
         result.button = info.band;
         if (info.band == BTN_OFF) begin
            connected_in = 1'b0;
            if (cont) result.stop_cmd = 1'b1;
         end

         if (!pending_ff) begin
            case (info.band) inside
               BTN_NONE, BTN_OFF: begin
                  if (cont) begin
                     result.stop_cmd = 1'b1;
                  end else if (up_short) begin
                     result.move_cmd        = MOVE_NUDGE_UP;
                     result.target_valid    = 1'b1;
                     result.target_position = item.current_position + NudgeS;
                  end else if (down_short) begin
                     result.move_cmd        = MOVE_NUDGE_DN;
                     result.target_valid    = 1'b1;
                     result.target_position = item.current_position - NudgeS;
                  end
                  up_at_in   = '0;
                  down_at_in = '0;
                  both_at_in = '0;
               end
               BTN_UP: begin
                  if (item.manual_busy && !cont) begin
                     result.stop_cmd = 1'b1;
                  end else if (up_at_ff == '0) begin
                     result.stop_cmd = 1'b1;
                     up_at_in   = now;
                     down_at_in = '0;
                     both_at_in = '0;
                  end else if (!cont && up_age > HoldT) begin
                     result.move_cmd = MOVE_CONT_UP;
                  end
               end
               BTN_DOWN: begin
                  if (item.manual_busy && !cont) begin
                     result.stop_cmd = 1'b1;
                  end else if (down_at_ff == '0) begin
                     result.stop_cmd = 1'b1;
                     up_at_in   = '0;
                     down_at_in = now;
                     both_at_in = '0;
                  end else if (!cont && down_age > HoldT) begin
                     result.move_cmd = MOVE_CONT_DN;
                  end
               end
               default: begin
                  // both buttons: arm a step mode change for the release
                  result.stop_cmd = 1'b1;
                  up_at_in   = '0;
                  down_at_in = '0;
                  both_at_in = now;
                  pending_in = 1'b1;
               end
            endcase
         end else if (released) begin
            if (both_age > ModeT) begin
               result.mode_valid    = 1'b1;
               result.new_step_mode = MODE_BASE;
            end else if (item.current_step_mode <= MODE_DOUBLE_MAX) begin
               result.mode_valid    = 1'b1;
               result.new_step_mode = {item.current_step_mode[MODE_W-2:0], 1'b0};
            end
            pending_in = 1'b0;
         end
      end

      result.linked = connected_in;
   end

   // State update once per processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         up_at_ff     <= '0;
         down_at_ff   <= '0;
         both_at_ff   <= '0;
         last_poll_ff <= '0;
         last_disc_ff <= '0;
         pending_ff   <= 1'b0;
      end else if (fire) begin
         connected_ff <= connected_in;
         up_at_ff     <= up_at_in;
         down_at_ff   <= down_at_in;
         both_at_ff   <= both_at_in;
         last_poll_ff <= last_poll_in;
         last_disc_ff <= last_disc_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

/* design/hand_controller_button_interpreter_top.sv */
// Top level of the hand controller button interpreter.
`timescale 1ns / 1ps
//
// Interprets a resistor-ladder hand controller, one tick per request transfer.
// req_if carries a tick: time in ms, four ADC samples, motor status flags,
// focuser position and step mode. rsp_if returns exactly one result per tick:
// decoded button, link status, stop and move commands, a nudge target and a
// new step mode. csr_* writes the eight 10-bit level thresholds by index.
// A tick taken into the input register has its result on rsp_if from the result register.
// Throughput: one tick per cycle while the receiver does not stall; the tick
// state (connection, press times, poll and discovery times) is read between the
// input register and the result register and updated as the result is registered.
// Reset clears the connection and all timing state, sets the thresholds to
// zero except the presence ceiling (all ones), and empties both registers.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more tick; further requests then wait.
// Thresholds are to be written by the user only while no tick is in flight; the block does not enforce it.
//
module hand_controller_button_interpreter_top
   import hcbi_pkg::*;
#(
   parameter int HOLD_TIMEOUT_MS       = 500,
   parameter int MODE_RESET_TIMEOUT_MS = 2000,
   parameter int POLL_MS               = 20,
   parameter int DISCOVERY_MS          = 300,
   parameter int NUDGE_STEPS           = 100
)(
   input  logic                 clock,
   input  logic                 reset,
   hcbi_req_if.sink             req_if,
   hcbi_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]   csr_wr_data
);

   cfg_type        cfg;
   req_item_type   req_item;
   req_item_type   item_ff;
   logic           item_valid_ff;
   level_info_type info;
   rsp_item_type   result;
   rsp_item_type   rsp_ff;
   logic           rsp_valid_ff;
   logic           advance;
   logic           req_take;

   // Flow control between input and result registers
   assign advance  = item_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !item_valid_ff || advance;

   assign req_item.now_ms            = req_if.now_ms;
   assign req_item.level_a           = req_if.level_a;
   assign req_item.level_b           = req_if.level_b;
   assign req_item.level_c           = req_if.level_c;
   assign req_item.level_d           = req_if.level_d;
   assign req_item.motor_busy        = req_if.motor_busy;
   assign req_item.manual_busy       = req_if.manual_busy;
   assign req_item.manual_continuous = req_if.manual_continuous;
   assign req_item.current_position  = req_if.current_position;
   assign req_item.current_step_mode = req_if.current_step_mode;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         item_valid_ff <= req_if.valid;
      end
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   hcbi_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wr_data),
      .cfg      (cfg)
   );

   hcbi_level u_level (
      .item (item_ff),
      .cfg  (cfg),
      .info (info)
   );

   hcbi_core #(
      .HOLD_TIMEOUT_MS       (HOLD_TIMEOUT_MS),
      .MODE_RESET_TIMEOUT_MS (MODE_RESET_TIMEOUT_MS),
      .POLL_MS               (POLL_MS),
      .DISCOVERY_MS          (DISCOVERY_MS),
      .NUDGE_STEPS           (NUDGE_STEPS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .info   (info),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.button          = rsp_ff.button;
   assign rsp_if.linked          = rsp_ff.linked;
   assign rsp_if.stop_cmd        = rsp_ff.stop_cmd;
   assign rsp_if.move_cmd        = rsp_ff.move_cmd;
   assign rsp_if.target_valid    = rsp_ff.target_valid;
   assign rsp_if.target_position = rsp_ff.target_position;
   assign rsp_if.mode_valid      = rsp_ff.mode_valid;
   assign rsp_if.new_step_mode   = rsp_ff.new_step_mode;

   // A nudge target only comes with a nudge move
   a_target_nudge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.target_valid |->
         (rsp_ff.move_cmd == MOVE_NUDGE_UP) || (rsp_ff.move_cmd == MOVE_NUDGE_DN))
      else $error("target without nudge move");

   // Not linked after a tick means no button was decoded
   a_unlinked_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.linked |-> rsp_ff.button == BTN_OFF)
      else $error("button decoded while unlinked");

   // A continuous move is never paired with a stop
   a_cont_no_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_ff.move_cmd == MOVE_CONT_UP) || (rsp_ff.move_cmd == MOVE_CONT_DN))
         |-> !rsp_ff.stop_cmd)
      else $error("stop with continuous move");

   // Nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !item_valid_ff)
      else $error("registers not empty after reset");

endmodule
